/* hdl/pmst_pkg.sv */
`default_nettype none

package pmst_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int NO_EDGE_DEF      = 9999;

  localparam int OP_W   = 2;
  localparam int VTX_W  = 4;
  localparam int WGT_W  = 14;
  localparam int TOT_W  = 18;
  localparam int VC_W   = 5;
  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_RUN   = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    U_IDLE = 3'd0,
    U_ADD1 = 3'd1,
    U_ADD2 = 3'd2,
    U_CLR  = 3'd3,
    U_INIT = 3'd4,
    U_SCAN = 3'd5,
    U_EMIT = 3'd6,
    U_STEP = 3'd7
  } upc_t;

  typedef enum logic [2:0] {
    C_TRUE      = 3'd0,
    C_IN_FIRE   = 3'd1,
    C_SWEEP_END = 3'd2,
    C_SCAN_END  = 3'd3,
    C_OUT_FREE  = 3'd4,
    C_RUN_OVER  = 3'd5
  } cond_sel_t;

  typedef enum logic {
    J_BRANCH   = 1'b0,
    J_DISPATCH = 1'b1
  } jmode_t;

  // Status flags from the datapath that the sequencer branches on.
  typedef struct packed {
    logic in_fire;
    logic sweep_end;
    logic scan_end;
    logic out_free;
    logic run_over;
  } cond_t;

  typedef struct packed {
    jmode_t    jmode;
    cond_sel_t cond;
    upc_t      target;
    upc_t      alt;
    logic      in_ready;
    logic      wr_ab;
    logic      wr_ba;
    logic      wr_clr;
    logic      run_start;
    logic      scan;
    logic      emit;
    logic      next_pick;
  } ctrl_t;

  // Control store. On a branch the next step is target when the condition
  // holds and alt otherwise; alt equal to the step itself makes it a wait.
  function automatic ctrl_t ucode(input upc_t s);
    ctrl_t c;
    c = '0;
    c.jmode = J_BRANCH;
    c.cond  = C_TRUE;
    c.target = U_IDLE;
    c.alt    = U_IDLE;
    case (s)
      U_IDLE: begin
        c.jmode = J_DISPATCH; c.cond = C_IN_FIRE; c.alt = U_IDLE; c.in_ready = 1'b1;
      end
      U_ADD1: begin
        c.target = U_ADD2; c.wr_ab = 1'b1;
      end
      U_ADD2: begin
        c.target = U_IDLE; c.wr_ba = 1'b1;
      end
      U_CLR: begin
        c.cond = C_SWEEP_END; c.target = U_IDLE; c.alt = U_CLR; c.wr_clr = 1'b1;
      end
      U_INIT: begin
        c.target = U_SCAN; c.run_start = 1'b1;
      end
      U_SCAN: begin
        c.cond = C_SCAN_END; c.target = U_EMIT; c.alt = U_SCAN; c.scan = 1'b1;
      end
      U_EMIT: begin
        c.cond = C_OUT_FREE; c.target = U_STEP; c.alt = U_EMIT; c.emit = 1'b1;
      end
      U_STEP: begin
        c.cond = C_RUN_OVER; c.target = U_IDLE; c.alt = U_SCAN; c.next_pick = 1'b1;
      end
      default: begin
        c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic upc_t dispatch(input op_t op);
    upc_t u;
    case (op)
      OP_ADD:   u = U_ADD1;
      OP_RUN:   u = U_INIT;
      OP_CLEAR: u = U_CLR;
      default:  u = U_IDLE;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

/* hdl/prim_mst_dense.sv */
// Minimum spanning tree by Prim's method over a dense cost matrix held in one
// single-port-write RAM. After reset the block sweeps the matrix to the no-edge
// value, one entry a cycle, and takes no transaction until that is done; a
// clear transaction runs the same sweep. An add-edge transaction is accepted
// and then makes one RAM write per mirrored entry. A run reads one matrix
// entry per cycle while it scans; for each chosen vertex it scans a row
// through the registered RAM read, hands the result to the output register
// (waiting while that register holds a result not yet taken), and then
// advances to the next pick. Results leave through an output register, so
// the next transaction is accepted while the last result of a run is still
// waiting to be taken.
`default_nettype none

module prim_mst_dense
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int NO_EDGE      = NO_EDGE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [VC_W-1:0]  cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  operation,
  input  wire logic [VTX_W-1:0] first_vertex,
  input  wire logic [VTX_W-1:0] second_vertex,
  input  wire logic [WGT_W-1:0] weight,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [VTX_W-1:0]      parent_vertex,
  output logic [VTX_W-1:0]      child_vertex,
  output logic [WGT_W-1:0]      edge_weight,
  output logic                  edge_valid,
  output logic [TOT_W-1:0]      total_cost,
  output logic                  disconnected,
  output logic                  last
);

  localparam int VW     = $clog2(MAX_VERTICES);
  localparam int NCW    = $clog2(MAX_VERTICES + 1);
  localparam int CW     = $clog2(NO_EDGE + 1);
  localparam int MDEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW     = $clog2(MDEPTH);
  localparam int VRW    = 1 + VW + CW;

  ctrl_t ctrl;
  cond_t cond;

  logic            in_fire;
  logic            emit_fire;

  logic [VC_W-1:0] vcount;
  logic [VW-1:0]   a_reg;
  logic [VW-1:0]   b_reg;
  logic [CW-1:0]   w_reg;
  logic            ok_reg;
  logic [AW-1:0]   swp;

  logic [NCW-1:0]  n_reg;
  logic [NCW-1:0]  n_next;
  logic [NCW-1:0]  j;
  logic [VW-1:0]   jd;
  logic            pv;
  logic            first;
  logic [VW-1:0]   pick;
  logic [NCW-1:0]  added;
  logic [CW-1:0]   best;
  logic [VW-1:0]   bidx;
  logic [VW-1:0]   bpar;
  logic            found;
  logic            finish;
  logic [TOT_W-1:0] total;
  logic [TOT_W-1:0] total_sum;
  logic            is_last_edge;

  logic            m_we;
  logic [AW-1:0]   m_waddr;
  logic [CW-1:0]   m_wdata;
  logic [AW-1:0]   m_raddr;
  logic [CW-1:0]   m_rdata;

  logic [VRW-1:0]  vr_rdata;
  logic [VRW-1:0]  vr_wdata;

  logic            old_in;
  logic [VW-1:0]   old_par;
  logic [CW-1:0]   old_dist;
  logic            tin;
  logic            upd;
  logic [CW-1:0]   nd;
  logic [VW-1:0]   np;
  logic            cand;

  pmst_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .op   (operation),
    .cond (cond),
    .ctrl (ctrl)
  );

  assign in_ready  = ctrl.in_ready;
  assign in_fire   = in_valid && ctrl.in_ready;
  assign emit_fire = ctrl.emit && cond.out_free;

  assign cond.in_fire   = in_fire;
  assign cond.sweep_end = (swp == AW'(MDEPTH - 1));
  assign cond.scan_end  = (j == n_reg);
  assign cond.out_free  = !out_valid || out_ready;
  assign cond.run_over  = finish;

  // Matrix write port: mirrored edge writes or the clearing sweep.
  always_comb begin
    m_we    = 1'b0;
    m_waddr = swp;
    m_wdata = CW'(NO_EDGE);
    if (ctrl.wr_clr) begin
      m_we = 1'b1;
    end else if (ctrl.wr_ab) begin
      m_we    = ok_reg;
      m_waddr = AW'(a_reg) * AW'(MAX_VERTICES) + AW'(b_reg);
      m_wdata = w_reg;
    end else if (ctrl.wr_ba) begin
      m_we    = ok_reg;
      m_waddr = AW'(b_reg) * AW'(MAX_VERTICES) + AW'(a_reg);
      m_wdata = w_reg;
    end
  end

  assign m_raddr = AW'(pick) * AW'(MAX_VERTICES) + AW'(j[VW-1:0]);

  pmst_ram #(.WIDTH(CW), .DEPTH(MDEPTH)) u_matrix (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  // Per-vertex record {in tree, best parent, best distance}. The first scan of
  // a run ignores what is stored and starts from an empty tree.
  pmst_ram #(.WIDTH(VRW), .DEPTH(MAX_VERTICES)) u_vertex (
    .clk   (clk),
    .we    (pv),
    .waddr (jd),
    .wdata (vr_wdata),
    .raddr (j[VW-1:0]),
    .rdata (vr_rdata)
  );

  // One column of the scan: relax through the newest tree vertex and track
  // the nearest outside vertex for the next pick, lowest index on a tie.
  always_comb begin
    old_in   = first ? 1'b0 : vr_rdata[VRW-1];
    old_par  = first ? '0 : vr_rdata[CW +: VW];
    old_dist = first ? CW'(NO_EDGE) : vr_rdata[CW-1:0];
    tin      = old_in || (jd == pick);
    upd      = !tin && (m_rdata < old_dist);
    nd       = upd ? m_rdata : old_dist;
    np       = upd ? pick : old_par;
    vr_wdata = {tin, np, nd};
    cand     = pv && !tin && (nd < best);
  end

  always_comb begin
    if (vcount == '0) begin
      n_next = NCW'(1);
    end else if (int'(vcount) > MAX_VERTICES) begin
      n_next = NCW'(MAX_VERTICES);
    end else begin
      n_next = NCW'(vcount);
    end
  end

  assign total_sum    = total + TOT_W'(best);
  assign is_last_edge = ((added + NCW'(1)) == n_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= VC_RESET;
      swp       <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        vcount <= cfg_data;
      end

      if (ctrl.wr_clr) begin
        swp <= cond.sweep_end ? '0 : swp + AW'(1);
      end

      if (ctrl.scan && (j < n_reg)) begin
        pv <= 1'b1;
      end else begin
        pv <= 1'b0;
      end

      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_reg  <= VW'(first_vertex);
      b_reg  <= VW'(second_vertex);
      ok_reg <= (int'(first_vertex) < MAX_VERTICES) &&
                (int'(second_vertex) < MAX_VERTICES);
      w_reg  <= (int'(weight) >= NO_EDGE) ? CW'(NO_EDGE) : CW'(weight);
    end

    if (ctrl.run_start) begin
      n_reg <= n_next;
      pick  <= '0;
      added <= NCW'(1);
      first <= 1'b1;
      total <= '0;
      j     <= '0;
      best  <= CW'(NO_EDGE);
      found <= 1'b0;
    end else if (ctrl.next_pick) begin
      pick  <= bidx;
      added <= added + NCW'(1);
      first <= 1'b0;
      j     <= '0;
      best  <= CW'(NO_EDGE);
      found <= 1'b0;
    end else begin
      if (ctrl.scan && (j < n_reg)) begin
        j  <= j + NCW'(1);
        jd <= j[VW-1:0];
      end
      if (cand) begin
        best  <= nd;
        bidx  <= jd;
        bpar  <= np;
        found <= 1'b1;
      end
    end

    if (emit_fire) begin
      if (n_reg == NCW'(1)) begin
        parent_vertex <= '0;
        child_vertex  <= '0;
        edge_weight   <= '0;
        edge_valid    <= 1'b0;
        total_cost    <= '0;
        disconnected  <= 1'b0;
        last          <= 1'b1;
        finish        <= 1'b1;
      end else if (found) begin
        parent_vertex <= VTX_W'(bpar);
        child_vertex  <= VTX_W'(bidx);
        edge_weight   <= WGT_W'(best);
        edge_valid    <= 1'b1;
        total_cost    <= total_sum;
        total         <= total_sum;
        disconnected  <= 1'b0;
        last          <= is_last_edge;
        finish        <= is_last_edge;
      end else begin
        parent_vertex <= '0;
        child_vertex  <= '0;
        edge_weight   <= '0;
        edge_valid    <= 1'b0;
        total_cost    <= total;
        disconnected  <= 1'b1;
        last          <= 1'b1;
        finish        <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/pmst_ram.sv */
`default_nettype none

module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/pmst_seq.sv */
`default_nettype none

module pmst_seq
  import pmst_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [OP_W-1:0] op,
  input  wire cond_t           cond,
  output ctrl_t                ctrl
);

  upc_t upc;
  upc_t upc_next;
  logic cond_hit;

  assign ctrl = ucode(upc);

  always_comb begin
    case (ctrl.cond)
      C_TRUE:      cond_hit = 1'b1;
      C_IN_FIRE:   cond_hit = cond.in_fire;
      C_SWEEP_END: cond_hit = cond.sweep_end;
      C_SCAN_END:  cond_hit = cond.scan_end;
      C_OUT_FREE:  cond_hit = cond.out_free;
      C_RUN_OVER:  cond_hit = cond.run_over;
      default:     cond_hit = 1'b0;
    endcase
    if (!cond_hit) begin
      upc_next = ctrl.alt;
    end else if (ctrl.jmode == J_DISPATCH) begin
      upc_next = dispatch(op_t'(op));
    end else begin
      upc_next = ctrl.target;
    end
  end

  // Reset starts in the clearing sweep so the matrix holds no edges.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_CLR;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

`default_nettype wire
